// ===== hw/rtl/bsfe_pkg.sv =====
// Package for the byte stuffing frame encoder: line codes, slot indexes, queue types.
`default_nettype none
package bsfe_pkg;

	// Line codes
	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7F;
	localparam logic [7:0] ESC_FLAG   = 8'h80;
	localparam logic [7:0] ESC_ESC    = 8'h81;
	localparam logic [7:0] BASE_RESET = 8'h55;

	// Output slots of one command, in line order
	localparam int NUM_SLOTS = 6;
	localparam int SLOT_W    = 3;
	localparam logic [SLOT_W-1:0] SLOT_OPEN  = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_DATA  = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_DATA2 = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_CHK   = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_CHK2  = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_CLOSE = 3'd5;

	// One classified item, passed from front to back
	typedef struct packed {
		logic       open;
		logic       has_byte;
		logic [7:0] data;
		logic       close;
		logic [7:0] chk;
	} cmd_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// True when a byte must go out as an escape pair
	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = (b == FLAG_BYTE) || (b == ESC_BYTE);
	endfunction

	// First line byte of a possibly escaped byte
	function automatic logic [7:0] first_code(input logic [7:0] b);
		first_code = needs_escape(b) ? ESC_BYTE : b;
	endfunction

	// Second line byte of an escape pair
	function automatic logic [7:0] second_code(input logic [7:0] b);
		second_code = (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bsfe_front.sv =====
// Front part: accepts input beats, keeps the running sum and forms queue commands.
`default_nettype none
module bsfe_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	input  wire logic [7:0]     cfg_data,
	input  wire logic           in_valid,
	input  wire logic [7:0]     payload_byte,
	input  wire logic           frame_first,
	input  wire logic           frame_last,
	input  wire logic           no_payload,
	input  wire bsfe_pkg::qstat_t qstat,
	output logic                in_stall,
	output logic                push,
	output bsfe_pkg::cmd_t      cmd
);
	import bsfe_pkg::*;

	logic [7:0] base_q;
	logic [7:0] sum_q;
	logic [7:0] sum_next;
	logic       accept;

	// Stall the sender while the queue has no room
	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;

	// Restart the sum on a first mark, add the byte when one is carried
	always_comb begin
		sum_next = (frame_first ? 8'd0 : sum_q) + (no_payload ? 8'd0 : payload_byte);
	end

	// Classify the beat into a command
	always_comb begin
		cmd.open     = frame_first;
		cmd.has_byte = !no_payload;
		cmd.data     = payload_byte;
		cmd.close    = frame_last;
		cmd.chk      = base_q - sum_next;
	end

	// Drop beats that cause no line byte
	assign push = accept && (frame_first || frame_last || !no_payload);

	// Hold the checksum base and the running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			sum_q  <= 8'd0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (accept) begin
				sum_q <= sum_next;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bsfe_queue.sv =====
// Command queue between front and back.
`default_nettype none
module bsfe_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire bsfe_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output bsfe_pkg::cmd_t      head_cmd,
	output bsfe_pkg::qstat_t    qstat
);
	import bsfe_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign qstat.full  = (count_q == CW'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign head_cmd    = mem_q[rd_ptr_q];

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/bsfe_back.sv =====
// Back part: walks the slots of the head command and drives the output register.
`default_nettype none
module bsfe_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bsfe_pkg::cmd_t   head_cmd,
	input  wire bsfe_pkg::qstat_t qstat,
	input  wire logic             out_stall,
	output logic                  pop,
	output logic                  out_valid,
	output logic [7:0]            line_byte,
	output logic                  run_last,
	output logic                  frame_done
);
	import bsfe_pkg::*;

	logic [SLOT_W-1:0]    slot_q;
	logic [NUM_SLOTS-1:0] slot_en;
	logic [NUM_SLOTS-1:0] pending;
	logic [NUM_SLOTS-1:0] rest;
	logic [SLOT_W-1:0]    pick;
	logic                 pick_last;
	logic                 advance;
	logic [7:0]           byte_next;
	logic                 out_valid_q;
	logic [7:0]           line_byte_q;
	logic                 run_last_q;
	logic                 frame_done_q;

	// Mark the slots this command fills
	always_comb begin
		slot_en             = '0;
		slot_en[SLOT_OPEN]  = head_cmd.open;
		slot_en[SLOT_DATA]  = head_cmd.has_byte;
		slot_en[SLOT_DATA2] = head_cmd.has_byte && needs_escape(head_cmd.data);
		slot_en[SLOT_CHK]   = head_cmd.close;
		slot_en[SLOT_CHK2]  = head_cmd.close && needs_escape(head_cmd.chk);
		slot_en[SLOT_CLOSE] = head_cmd.close;
	end

	// Pick the lowest slot not yet sent
	always_comb begin
		pending = slot_en & ({NUM_SLOTS{1'b1}} << slot_q);
		pick    = SLOT_CLOSE;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				pick = SLOT_W'(i);
			end
		end
		rest      = pending & ~(NUM_SLOTS'(1) << pick);
		pick_last = (rest == '0);
	end

	// Encode the picked slot
	always_comb begin
		case (pick)
			SLOT_OPEN:  byte_next = FLAG_BYTE;
			SLOT_DATA:  byte_next = first_code(head_cmd.data);
			SLOT_DATA2: byte_next = second_code(head_cmd.data);
			SLOT_CHK:   byte_next = first_code(head_cmd.chk);
			SLOT_CHK2:  byte_next = second_code(head_cmd.chk);
			default:    byte_next = FLAG_BYTE;
		endcase
	end

	// Move one slot whenever the queue is not empty and the output register is free or drains
	assign advance = !qstat.empty && (!out_valid_q || !out_stall);
	assign pop     = advance && pick_last;

	// Step the slot pointer, restart it on the next command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_OPEN;
		end else if (advance) begin
			slot_q <= pick_last ? SLOT_OPEN : pick + 1'b1;
		end
	end

	// Hold the output beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			line_byte_q  <= byte_next;
			run_last_q   <= pick_last;
			frame_done_q <= (pick == SLOT_CLOSE);
		end
	end

	assign out_valid  = out_valid_q;
	assign line_byte  = line_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/byte_stuff_frame_encoder.sv =====
// Top level of the byte stuffing frame encoder with additive checksum.
//
// Input channel (in_valid / in_stall): one payload byte per beat with
// frame_first, frame_last and no_payload marks. A first mark sends the
// opening flag 0x7E and clears the sum; a last mark appends the escaped
// checksum (checksum_base - sum) and the closing flag. 0x7E and 0x7F in the
// data or checksum go out as 0x7F 0x80 and 0x7F 0x81.
// Output channel (out_valid / out_stall): one line byte per beat; run_last
// marks the last byte caused by an input beat, frame_done the closing flag.
// Config channel (cfg_valid / cfg_ready): writes checksum_base; always ready.
// It must be written while the block is idle; the block does not enforce this.
// The first line byte of a beat passes the command queue and the output
// register after the beat is accepted. One line byte per cycle while the
// receiver does not stall; a beat yields 1 to 6 line bytes in slot order.
// The front keeps accepting beats while the QUEUE_DEPTH entry command
// queue has room, and stalls the sender when full.
// Reset clears the queue, the sum and the output, and sets checksum_base to
// 0x55. While the receiver stalls, the output beat holds and the queue fills.
`default_nettype none
module byte_stuff_frame_encoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] payload_byte,
	input  wire logic       frame_first,
	input  wire logic       frame_last,
	input  wire logic       no_payload,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      line_byte,
	output logic            run_last,
	output logic            frame_done
);
	import bsfe_pkg::*;

	cmd_t   push_cmd;
	cmd_t   head_cmd;
	qstat_t qstat;
	logic   push;
	logic   pop;

	assign cfg_ready = 1'b1;

	bsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.payload_byte (payload_byte),
		.frame_first  (frame_first),
		.frame_last   (frame_last),
		.no_payload   (no_payload),
		.qstat        (qstat),
		.in_stall     (in_stall),
		.push         (push),
		.cmd          (push_cmd)
	);

	bsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.qstat    (qstat)
	);

	bsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.qstat      (qstat),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.line_byte  (line_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

	// Never write a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("command queue overflow");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("command queue underflow");

	// The closing flag ends its beat's run
	a_close_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (line_byte == FLAG_BYTE && run_last))
		else $error("closing flag malformed");

	// An escape byte is never the end of a run
	a_escape_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && line_byte == ESC_BYTE) |-> !run_last)
		else $error("escape byte ends a run");

endmodule
`default_nettype wire

// ===== verif/byte_stuff_frame_encoder_tb.sv =====
// Testbench for the byte stuffing frame encoder: directed and random frames checked per line byte.
`timescale 1ns / 1ps
module byte_stuff_frame_encoder_tb;
	import bsfe_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 20;

	// One expected line beat
	typedef struct packed {
		logic [7:0] code;
		logic       last_of_item;
		logic       closes;
	} line_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] payload_byte = 8'h00;
	logic       frame_first = 1'b0;
	logic       frame_last = 1'b0;
	logic       no_payload = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] line_byte;
	logic       run_last;
	logic       frame_done;

	// Predictor state and expected line beats
	logic [7:0] chk_base = BASE_RESET;
	logic [7:0] frame_sum = 8'h00;
	logic [7:0] item_codes[$];
	line_beat_t pending_beats[$];
	line_beat_t want;

	int err_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;

	byte_stuff_frame_encoder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.payload_byte(payload_byte),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.no_payload  (no_payload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.line_byte   (line_byte),
		.run_last    (run_last),
		.frame_done  (frame_done)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Randomly stall the output side
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < out_idle_pct);
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		$display("%0t mismatch %s: got %02h want %02h", $time, what, got, exp_val);
		err_count++;
	endtask

	// Append one byte to the current run, escaped if it is a line code
	function automatic void add_coded(input logic [7:0] b);
		if (b == FLAG_BYTE) begin
			item_codes.push_back(ESC_BYTE);
			item_codes.push_back(ESC_FLAG);
		end else if (b == ESC_BYTE) begin
			item_codes.push_back(ESC_BYTE);
			item_codes.push_back(ESC_ESC);
		end else begin
			item_codes.push_back(b);
		end
	endfunction

	// Compute the line beats caused by one accepted item
	function automatic void encode_item(input logic [7:0] b, input logic first,
			input logic last, input logic nopay);
		line_beat_t lb;
		item_codes.delete();
		if (first) begin
			frame_sum = 8'h00;
			item_codes.push_back(FLAG_BYTE);
		end
		if (!nopay) begin
			add_coded(b);
			frame_sum = frame_sum + b;
		end
		if (last) begin
			add_coded(chk_base - frame_sum);
			item_codes.push_back(FLAG_BYTE);
		end
		foreach (item_codes[i]) begin
			lb.code = item_codes[i];
			lb.last_of_item = (i == item_codes.size() - 1);
			lb.closes = last && (i == item_codes.size() - 1);
			pending_beats.push_back(lb);
		end
	endfunction

	// Check each accepted line beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("unexpected line beat", line_byte, 8'h00);
			end else begin
				want = pending_beats.pop_front();
				if (line_byte !== want.code)
					report_mismatch("line_byte", line_byte, want.code);
				if (run_last !== want.last_of_item)
					report_mismatch("run_last", {7'd0, run_last}, {7'd0, want.last_of_item});
				if (frame_done !== want.closes)
					report_mismatch("frame_done", {7'd0, frame_done}, {7'd0, want.closes});
			end
		end
	end

	// Send one item; hold it until accepted, then predict its beats
	task automatic send_item(input logic [7:0] b, input logic first, input logic last,
			input logic nopay);
		@(negedge clk);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		payload_byte = b;
		frame_first = first;
		frame_last = last;
		no_payload = nopay;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_item(b, first, last, nopay);
		if (!nopay || first || last)
			items_sent++;
	endtask

	// Drop valid and wait until every expected beat has come
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	// Write checksum_base once the block is idle
	task automatic write_checksum_base(input logic [7:0] v);
		drain();
		repeat (QUIET_CYCLES) @(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		chk_base = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte();
		logic [1:0] sel;
		sel = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 25) begin
			case (sel)
				2'd0: return FLAG_BYTE;
				2'd1: return ESC_BYTE;
				2'd2: return 8'h00;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic test_empty_frame();
		send_item(8'h00, 1'b1, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1, 1'b1);
	endtask

	task automatic test_byte_escapes();
		// Multi-byte frame across the byte extremes and both line codes
		send_item(8'h00, 1'b1, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0, 1'b0);
		send_item(FLAG_BYTE, 1'b0, 1'b0, 1'b0);
		send_item(ESC_BYTE, 1'b0, 1'b0, 1'b0);
		send_item(ESC_FLAG, 1'b0, 1'b1, 1'b0);
		// Single-item frames with a line code as data, then with the checksum as each line code
		send_item(FLAG_BYTE, 1'b1, 1'b1, 1'b0);
		send_item(BASE_RESET - FLAG_BYTE, 1'b1, 1'b1, 1'b0);
		send_item(BASE_RESET - ESC_BYTE, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_partial_marks();
		// Opening and closing items that carry no byte
		send_item(8'hA5, 1'b1, 1'b0, 1'b1);
		send_item(8'h3C, 1'b0, 1'b0, 1'b0);
		send_item(8'h5A, 1'b0, 1'b0, 1'b1);
		send_item(8'hC3, 1'b0, 1'b1, 1'b1);
		// Continue after a closed frame without a first mark
		send_item(ESC_ESC, 1'b0, 1'b0, 1'b0);
		send_item(8'h01, 1'b0, 1'b1, 1'b0);
		// Reopen a frame that was never closed
		send_item(8'h10, 1'b1, 1'b0, 1'b0);
		send_item(8'h20, 1'b1, 1'b1, 1'b0);
	endtask

	task automatic test_checksum_base();
		write_checksum_base(8'h00);
		send_item(8'h01, 1'b1, 1'b1, 1'b0);
		write_checksum_base(8'hFF);
		send_item(8'h00, 1'b1, 1'b1, 1'b1);
		send_item(8'h80, 1'b1, 1'b1, 1'b0);
		write_checksum_base(ESC_BYTE);
		send_item(8'h00, 1'b1, 1'b1, 1'b1);
		write_checksum_base(FLAG_BYTE);
		send_item(8'h00, 1'b1, 1'b1, 1'b1);
	endtask

	// Mostly well-formed frames with random content, some loose items
	task automatic test_random_frames(input int in_pct, input int out_pct, input int count,
			input bit hold_off);
		int start;
		int len;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		write_checksum_base(8'($urandom_range(0, 255)));
		in_idle_pct = in_pct;
		out_idle_pct = out_pct;
		while (items_sent - start < count) begin
			if (hold_off && !paused && items_sent - start >= count / 2) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 99) < 15) begin
				send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				len = $urandom_range(0, 6);
				if (len == 0) begin
					send_item(pick_byte(), 1'b1, 1'b1, 1'b1);
				end else begin
					for (int i = 0; i < len; i++)
						send_item(pick_byte(), i == 0, i == len - 1, 1'b0);
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_frame();
		test_byte_escapes();
		test_partial_marks();
		test_checksum_base();
		test_random_frames(8, 62, 119, 1'b1);
		test_random_frames(62, 8, 119, 1'b0);
		test_random_frames(0, 0, 119, 1'b0);

		drain();
		out_idle_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch("beats still expected", 8'h00, 8'(pending_beats.size()));
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
